>>> src/omr_pkg.sv
// Shared constants and types for the ordered multiset rank engine.
package omr_pkg;
    localparam int CAPACITY   = 1024;
    localparam int COUNT_BITS = 24;
    localparam int AW         = $clog2(CAPACITY);
    localparam int CW         = $clog2(CAPACITY + 1);
    localparam int KW         = 32;
    localparam int RW         = COUNT_BITS + 1;
    localparam int IN_W       = 64;
    localparam int OUT_W      = 64;

    localparam logic [2:0] MODE_INS  = 3'd0;
    localparam logic [2:0] MODE_DEL  = 3'd1;
    localparam logic [2:0] MODE_RANK = 3'd2;
    localparam logic [2:0] MODE_KTH  = 3'd3;
    localparam logic [2:0] MODE_PRED = 3'd4;
    localparam logic [2:0] MODE_SUCC = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

    typedef struct packed {
        logic [KW-1:0]         key;
        logic [COUNT_BITS-1:0] mult;
    } t_node;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_EV   = 8'b0000_0100,
        S_DEC  = 8'b0000_1000,
        S_SHRD = 8'b0001_0000,
        S_SHWR = 8'b0010_0000,
        S_PUT  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;
endpackage

>>> src/ordered_multiset_rank_engine_core.sv
// Top level: sorted node table in one RAM, scanned and shifted by a sequencer.
//
// channel | dir | fields (tdata, low bit first)
// s       | in  | mode[2:0], value[34:3], position[58:35], zero fill to 64
// m       | out | result_value[31:0], result_rank[56:32], status[58:57], zero fill
//
// A request scans every live node (one RAM read port, a read and an evaluate
// state per entry scanned). An insert adds a node write plus a read and a write
// per entry moved; a delete adds a read and a write per entry moved, or one write
// when it only lowers a multiplicity. Reset empties the table at once,
// no clearing pass. Input is taken only in the idle state; a held result
// blocks only the next completion.
module ordered_multiset_rank_engine_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [omr_pkg::IN_W-1:0]  i_s_tdata,  // mode, value, position
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [omr_pkg::OUT_W-1:0] o_m_tdata   // result_value, result_rank, status
);
    import omr_pkg::*;

    t_state                r_state;
    logic [CW-1:0]         r_count;
    logic [COUNT_BITS-1:0] r_total;

    // latched request
    logic [2:0]            r_mode;
    logic [KW-1:0]         r_val;
    logic [COUNT_BITS-1:0] r_pos;

    // scan accumulators
    logic [CW-1:0]         r_j;
    logic [CW-1:0]         r_idx;
    logic [COUNT_BITS-1:0] r_less;
    logic [COUNT_BITS-1:0] r_rem;
    logic                  r_kfound;
    logic [KW-1:0]         r_kval;
    logic                  r_here;
    logic [COUNT_BITS-1:0] r_here_mult;
    logic                  r_has_pred;
    logic [KW-1:0]         r_pred;
    logic                  r_has_succ;
    logic [KW-1:0]         r_succ;

    // update plan
    logic                  r_up;
    logic [CW-1:0]         r_p;
    logic [AW-1:0]         r_put_addr;
    t_node                 r_put_data;
    logic                  r_cnt_inc, r_cnt_dec, r_tot_inc, r_tot_dec;

    // result
    logic [KW-1:0]         r_res_val;
    logic [RW-1:0]         r_res_rank;
    logic [1:0]            r_res_st;
    logic                  r_ovalid;
    logic [KW-1:0]         r_o_val;
    logic [RW-1:0]         r_o_rank;
    logic [1:0]            r_o_st;

    // node RAM
    t_node                 r_mem [CAPACITY];
    t_node                 r_mem_q;
    logic [AW-1:0]         n_ra;
    logic                  n_we;
    logic [AW-1:0]         n_wa;
    t_node                 n_wd;

    logic [CW-1:0]         n_src;
    logic                  s_acc;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_o_st, r_o_rank, r_o_val};

    assign n_src = r_up ? (r_p - CW'(1)) : (r_p + CW'(1));

    // RAM port control
    always_comb begin
        n_ra = r_j[AW-1:0];
        n_we = 1'b0;
        n_wa = r_put_addr;
        n_wd = r_put_data;
        case (r_state)
            S_SHRD: n_ra = n_src[AW-1:0];
            S_SHWR: begin
                n_we = 1'b1;
                n_wa = r_p[AW-1:0];
                n_wd = r_mem_q;
            end
            S_PUT:  n_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_wa] <= n_wd;
        end
        r_mem_q <= r_mem[n_ra];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_mode     <= i_s_tdata[2:0];
                        r_val      <= i_s_tdata[34:3];
                        r_pos      <= i_s_tdata[58:35];
                        r_rem      <= i_s_tdata[58:35];
                        r_j        <= '0;
                        r_idx      <= '0;
                        r_less     <= '0;
                        r_kfound   <= 1'b0;
                        r_kval     <= '0;
                        r_here     <= 1'b0;
                        r_has_pred <= 1'b0;
                        r_pred     <= '0;
                        r_has_succ <= 1'b0;
                        r_succ     <= '0;
                        r_state    <= (r_count == '0) ? S_DEC : S_RD;
                    end
                end
                S_RD: r_state <= S_EV;
                S_EV: begin
                    // keys are sorted: evaluate one entry per visit
                    if ($signed(r_mem_q.key) < $signed(r_val)) begin
                        r_less     <= r_less + r_mem_q.mult;
                        r_idx      <= r_j + CW'(1);
                        r_has_pred <= 1'b1;
                        r_pred     <= r_mem_q.key;
                    end
                    if (r_mem_q.key == r_val) begin
                        r_here      <= 1'b1;
                        r_here_mult <= r_mem_q.mult;
                    end
                    if ($signed(r_mem_q.key) > $signed(r_val) && !r_has_succ) begin
                        r_has_succ <= 1'b1;
                        r_succ     <= r_mem_q.key;
                    end
                    if (!r_kfound) begin
                        if (r_rem <= r_mem_q.mult) begin
                            r_kfound <= 1'b1;
                            r_kval   <= r_mem_q.key;
                        end else begin
                            r_rem <= r_rem - r_mem_q.mult;
                        end
                    end
                    r_j     <= r_j + CW'(1);
                    r_state <= (r_j + CW'(1) == r_count) ? S_DEC : S_RD;
                end
                S_DEC: begin
                    r_res_val  <= '0;
                    r_res_rank <= '0;
                    r_res_st   <= ST_OK;
                    r_cnt_inc  <= 1'b0;
                    r_cnt_dec  <= 1'b0;
                    r_tot_inc  <= 1'b0;
                    r_tot_dec  <= 1'b0;
                    r_state    <= S_OUT;
                    case (r_mode)
                        MODE_INS: begin
                            if (r_total >= COUNT_LIMIT) begin
                                r_res_st <= ST_FULL;
                            end else if (r_here) begin
                                r_tot_inc  <= 1'b1;
                                r_put_addr <= r_idx[AW-1:0];
                                r_put_data <= '{key: r_val, mult: r_here_mult + 1'b1};
                                r_state    <= S_PUT;
                            end else if (r_count >= CW'(CAPACITY)) begin
                                r_res_st <= ST_FULL;
                            end else begin
                                r_tot_inc  <= 1'b1;
                                r_cnt_inc  <= 1'b1;
                                r_put_addr <= r_idx[AW-1:0];
                                r_put_data <= '{key: r_val, mult: COUNT_BITS'(1)};
                                r_up       <= 1'b1;
                                r_p        <= r_count;
                                r_state    <= (r_idx == r_count) ? S_PUT : S_SHRD;
                            end
                        end
                        MODE_DEL: begin
                            if (!r_here) begin
                                r_res_st <= ST_NONE;
                            end else if (r_here_mult > COUNT_BITS'(1)) begin
                                r_tot_dec  <= 1'b1;
                                r_put_addr <= r_idx[AW-1:0];
                                r_put_data <= '{key: r_val, mult: r_here_mult - 1'b1};
                                r_state    <= S_PUT;
                            end else begin
                                r_tot_dec <= 1'b1;
                                r_cnt_dec <= 1'b1;
                                r_up      <= 1'b0;
                                r_p       <= r_idx;
                                r_state   <= (r_idx + CW'(1) == r_count) ? S_OUT : S_SHRD;
                            end
                        end
                        MODE_RANK: r_res_rank <= RW'(r_less) + RW'(1);
                        MODE_KTH: begin
                            if (r_pos == '0 || r_pos > r_total) begin
                                r_res_st <= ST_RANGE;
                            end else begin
                                r_res_val <= r_kval;
                            end
                        end
                        MODE_PRED: begin
                            if (r_has_pred) r_res_val <= r_pred;
                            else            r_res_st  <= ST_NONE;
                        end
                        MODE_SUCC: begin
                            if (r_has_succ) r_res_val <= r_succ;
                            else            r_res_st  <= ST_NONE;
                        end
                        default: ;
                    endcase
                end
                S_SHRD: r_state <= S_SHWR;
                S_SHWR: begin
                    // move one entry, then step toward the insertion point (insert) or toward the table end (delete)
                    if (r_up) begin
                        if (r_p - CW'(1) == r_idx) begin
                            r_state <= S_PUT;
                        end else begin
                            r_p     <= r_p - CW'(1);
                            r_state <= S_SHRD;
                        end
                    end else begin
                        if (r_p + CW'(2) == r_count) begin
                            r_state <= S_OUT;
                        end else begin
                            r_p     <= r_p + CW'(1);
                            r_state <= S_SHRD;
                        end
                    end
                end
                S_PUT: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_o_val  <= r_res_val;
                        r_o_rank <= r_res_rank;
                        r_o_st   <= r_res_st;
                        if (r_cnt_inc) r_count <= r_count + CW'(1);
                        if (r_cnt_dec) r_count <= r_count - CW'(1);
                        if (r_tot_inc) r_total <= r_total + COUNT_BITS'(1);
                        if (r_tot_dec) r_total <= r_total - COUNT_BITS'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> tb/tb_top.sv
// Testbench for the ordered multiset rank engine: directed and random requests.
`timescale 1ns / 1ps

module tb_top;
    import omr_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata;   // mode[2:0], value[34:3], position[58:35], zero fill
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [OUT_W-1:0]  o_m_tdata;   // result_value[31:0], result_rank[56:32], status[58:57]

    typedef struct packed {
        logic [KW-1:0] rvalue;
        logic [RW-1:0] rrank;
        logic [1:0]    status;
    } t_answer;

    int unsigned errors = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
    endtask

    // Sorted multiset predictor plus queue of pending answers
    class multiset_board;
        logic [KW-1:0]         keys[$];
        logic [COUNT_BITS-1:0] mults[$];
        longint unsigned       total;
        t_answer               pending[$];

        function new();
            total = 0;
        endfunction

        // first index whose key is >= v (signed order)
        function int lower_idx(logic signed [KW-1:0] v);
            int i;
            for (i = 0; i < keys.size(); i++)
                if ($signed(keys[i]) >= v) return i;
            return keys.size();
        endfunction

        function void note_request(logic [2:0] mode, logic [KW-1:0] v,
                                   logic [COUNT_BITS-1:0] k);
            t_answer a;
            int i, j;
            bit here;
            longint unsigned less, rem;
            a = '0;
            i = lower_idx(v);
            here = (i < keys.size()) && (keys[i] == v);
            case (mode)
                MODE_INS: begin
                    if (total >= COUNT_LIMIT) a.status = ST_FULL;
                    else if (here) begin
                        mults[i]++; total++;
                    end else if (keys.size() >= CAPACITY) a.status = ST_FULL;
                    else begin
                        keys.insert(i, v); mults.insert(i, 1); total++;
                    end
                end
                MODE_DEL: begin
                    if (!here) a.status = ST_NONE;
                    else begin
                        mults[i]--; total--;
                        if (mults[i] == 0) begin
                            keys.delete(i); mults.delete(i);
                        end
                    end
                end
                MODE_RANK: begin
                    less = 0;
                    for (j = 0; j < i; j++) less += mults[j];
                    a.rrank = RW'(less + 1);
                end
                MODE_KTH: begin
                    if (k == 0 || k > total) a.status = ST_RANGE;
                    else begin
                        rem = k;
                        for (j = 0; j < keys.size(); j++) begin
                            if (rem <= mults[j]) begin
                                a.rvalue = keys[j];
                                break;
                            end
                            rem -= mults[j];
                        end
                    end
                end
                MODE_PRED: begin
                    if (i == 0) a.status = ST_NONE;
                    else a.rvalue = keys[i-1];
                end
                MODE_SUCC: begin
                    j = here ? i + 1 : i;
                    if (j >= keys.size()) a.status = ST_NONE;
                    else a.rvalue = keys[j];
                end
                default: ;
            endcase
            pending.push_back(a);
        endfunction

        task check_result(logic [OUT_W-1:0] d);
            t_answer w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", d, 0);
                return;
            end
            w = pending.pop_front();
            if (d[31:0] !== w.rvalue) report_mismatch("result_value", d[31:0], w.rvalue);
            if (d[56:32] !== w.rrank) report_mismatch("result_rank", d[56:32], w.rrank);
            if (d[58:57] !== w.status) report_mismatch("status", d[58:57], w.status);
            if (d[63:59] !== '0) report_mismatch("fill bits", d[63:59], 0);
        endtask
    endclass

    multiset_board board = new();

    ordered_multiset_rank_engine_core u_top (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Scoreboard hooks on accepted items
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            board.note_request(i_s_tdata[2:0], i_s_tdata[34:3], i_s_tdata[58:35]);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result(o_m_tdata);
    end

    // Watchdog on cycles with no acceptance
    int unsigned quiet = 0;
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 200000) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random stalls, one long hold-off
    bit long_hold = 0;
    bit sink_calm = 0;
    initial begin
        int n;
        i_m_tready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_m_tready <= 0;
                repeat (2000) @(posedge i_clk);
                long_hold = 0;
            end
            n = sink_calm ? 0 : gap_len();
            if (n > 0) begin
                i_m_tready <= 0;
                repeat (n) @(posedge i_clk);
            end
            i_m_tready <= 1;
            @(posedge i_clk);
        end
    end

    // valid stays high between back-to-back items
    task automatic send_req(input logic [2:0] mode, input logic [31:0] v,
                            input logic [23:0] k);
        i_s_tvalid <= 1;
        i_s_tdata <= {5'b0, k, v, mode};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_gap();
        int n;
        n = gap_len();
        if (n > 0) begin
            i_s_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    logic [31:0] pool[16];

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return pool[$urandom_range(0, 15)];
        if (r < 8) return pool[$urandom_range(0, 15)] + ($urandom_range(0, 1) ? 1 : -1);
        return $urandom;
    endfunction

    initial begin
        int i;
        logic [2:0] m;
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: empty-set queries, extremes, duplicates, absent delete, unused modes
        send_req(MODE_RANK, 32'h0, 0);
        send_req(MODE_KTH, 32'h0, 1);
        send_req(MODE_PRED, 32'h0, 0);
        send_req(MODE_SUCC, 32'h0, 0);
        send_req(MODE_DEL, 32'h5, 0);
        send_req(MODE_INS, 32'h8000_0000, 0);
        send_req(MODE_INS, 32'h7FFF_FFFF, 0);
        send_req(MODE_INS, 32'h0, 0);
        send_req(MODE_INS, 32'h0, 0);
        send_req(MODE_KTH, 32'h0, 0);
        send_req(MODE_KTH, 32'h0, 3);
        send_req(MODE_KTH, 32'h0, 4);
        send_req(MODE_KTH, 32'h0, 5);
        send_req(MODE_KTH, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_req(MODE_RANK, 32'h7FFF_FFFF, 0);
        send_req(MODE_RANK, 32'h8000_0000, 0);
        send_req(MODE_PRED, 32'h8000_0000, 0);
        send_req(MODE_SUCC, 32'h7FFF_FFFF, 0);
        send_req(MODE_SUCC, 32'h0, 0);
        send_req(MODE_PRED, 32'h0, 0);
        send_req(3'd6, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_req(3'd7, 32'h1234_5678, 24'h0);
        send_req(MODE_DEL, 32'h0, 0);
        send_req(MODE_DEL, 32'h0, 0);
        send_req(MODE_DEL, 32'h0, 0);

        // Sender pauses until everything has come back
        drain();

        for (i = 0; i < 16; i++) pool[i] = $urandom;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;

        // Random phase; hold the receiver off once midway to fill the block
        for (i = 0; i < 750; i++) begin
            if (i == 300) long_hold = 1;
            if (i == 500) sink_calm = 1;
            if (i == 600) sink_calm = 0;
            m = $urandom_range(0, 99) < 35 ? MODE_INS : 3'($urandom_range(1, 7));
            if (m == 3'd6 || m == 3'd7) m = $urandom_range(0, 3) == 0 ? m : MODE_RANK;
            send_req(m, pick_value(),
                     $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 40)));
            if (!sink_calm && i % 5 == 0) send_gap();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
